[rtl/core/ecpa_pkg.sv]
// Shared constants for the affine elliptic curve point adder.
// No dependencies; imported by the core and its port checker.
package ecpa_pkg;
    localparam int DATA_W    = 64;
    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CURVE_A = 8'd1;
endpackage

[rtl/core/ec_point_add_prime_field.sv]
// Affine point addition R = P + Q on y^2 = x^3 + a*x + b mod p.
// Depends on ecpa_pkg. One shared modular add/sub unit under a sequencer.
//
// channel   | handshake               | payload
// ----------+-------------------------+-----------------------------------
// request   | i_start, o_busy         | i_px, i_py, i_qx, i_qy
// result    | o_valid (one cycle)     | o_rx, o_ry, o_at_infinity
// config    | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// A request first reduces its five operands, then runs one check; unless the
// sum is at infinity, three W-bit multiplies follow (a fourth for doubling)
// and the Euclid inverse (each remainder step finds its quotient bit by
// bit), W = FIELD_BITS.
// Reset is synchronous, active low: modulus returns to 3, curve_a to 0.
// The result strobe lasts one cycle; the receiver cannot stall it.
module ec_point_add_prime_field #(
    parameter int FIELD_BITS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [ecpa_pkg::DATA_W-1:0]     i_px,
    input  logic [ecpa_pkg::DATA_W-1:0]     i_py,
    input  logic [ecpa_pkg::DATA_W-1:0]     i_qx,
    input  logic [ecpa_pkg::DATA_W-1:0]     i_qy,
    output logic                            o_valid,
    output logic [ecpa_pkg::DATA_W-1:0]     o_rx,
    output logic [ecpa_pkg::DATA_W-1:0]     o_ry,
    output logic                            o_at_infinity,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ecpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ecpa_pkg::DATA_W-1:0]     i_cfg_data
);
    import ecpa_pkg::*;

    localparam int W     = FIELD_BITS;
    localparam int CNT_W = $clog2(FIELD_BITS);
    localparam int K_W   = $clog2(FIELD_BITS + 1);

    typedef enum logic [4:0] {
        S_IDLE, S_RED, S_CHK, S_MUL_D, S_MUL_A, S_DBL_A1, S_DBL_A2, S_DBL_A3,
        S_DBL_DEN, S_GEN_NUM, S_GEN_DEN, S_INV_INIT, S_INV_TEST, S_INV_GROW,
        S_INV_DBL, S_INV_ADD, S_INV_SUB, S_INV_FIN, S_S_SQ, S_RX1, S_RX2,
        S_DX, S_RY
    } t_state;

    t_state              r_state, r_ret;
    logic [DATA_W-1:0]   r_cfg_mod, r_cfg_a;
    logic [W-1:0]        r_m;
    logic [W-1:0]        r_v [5];
    logic [W-1:0]        r_acc, r_ma, r_mb, r_num, r_den, r_s;
    logic [W-1:0]        r_r0, r_r1, r_t0, r_t1;
    logic [W:0]          r_d;
    logic [K_W-1:0]      r_k;
    logic [CNT_W-1:0]    r_cnt;
    logic [2:0]          r_ridx;
    logic                r_qb;
    logic                r_valid, r_inf;
    logic [W-1:0]        r_rx, r_ry;

    logic [W-1:0]        u_a, u_b, u_res, m_eff;
    logic                u_cin, u_sub;
    logic [W:0]          u_sum, u_red, u_dif, rem_dif, d_dbl;
    logic                n_valid;

    assign m_eff = (r_cfg_mod[W-1:0] < W'(3)) ? W'(3) : r_cfg_mod[W-1:0];

    always_comb begin
        u_a   = r_acc;
        u_b   = r_acc;
        u_cin = 1'b0;
        u_sub = 1'b0;
        case (r_state)
            S_RED:     u_cin = r_v[0][W-1];
            S_CHK:     begin u_a = r_v[1]; u_b = r_v[3]; end
            S_MUL_A:   u_b = r_ma;
            S_DBL_A2:  u_a = r_num;
            S_DBL_A3:  begin u_a = r_num; u_b = r_v[4]; end
            S_DBL_DEN: begin u_a = r_v[1]; u_b = r_v[1]; end
            S_GEN_NUM: begin u_a = r_v[3]; u_b = r_v[1]; u_sub = 1'b1; end
            S_GEN_DEN: begin u_a = r_v[2]; u_b = r_v[0]; u_sub = 1'b1; end
            S_INV_ADD: u_b = r_t1;
            S_INV_SUB: begin u_a = r_t0; u_b = r_acc; u_sub = 1'b1; end
            S_RX1:     begin u_b = r_v[0]; u_sub = 1'b1; end
            S_RX2:     begin u_a = r_num; u_b = r_v[2]; u_sub = 1'b1; end
            S_DX:      begin u_a = r_v[0]; u_b = r_num; u_sub = 1'b1; end
            S_RY:      begin u_b = r_v[1]; u_sub = 1'b1; end
            default:   u_sub = 1'b0;
        endcase
        u_sum   = {1'b0, u_a} + {1'b0, u_b} + (W+1)'(u_cin);
        u_red   = u_sum - {1'b0, r_m};
        u_dif   = {1'b0, u_a} - {1'b0, u_b};
        if (u_sub) begin
            u_res = u_dif[W] ? (u_dif[W-1:0] + r_m) : u_dif[W-1:0];
        end else begin
            u_res = u_red[W] ? u_sum[W-1:0] : u_red[W-1:0];
        end
        rem_dif = {1'b0, r_r0} - r_d;
        d_dbl   = {r_d[W-1:0], 1'b0};
        n_valid = (r_state == S_RY) ||
                  ((r_state == S_CHK) && (r_v[0] == r_v[2]) && (u_res == '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_state   <= S_IDLE;
            r_ret     <= S_IDLE;
            r_cfg_mod <= DATA_W'(3);
            r_cfg_a   <= '0;
        end else begin
            r_valid <= n_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MODULUS) begin
                    r_cfg_mod <= i_cfg_data;
                end else if (i_cfg_index == CFG_CURVE_A) begin
                    r_cfg_a <= i_cfg_data;
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_v[0] <= i_px[W-1:0];
                        r_v[1] <= i_py[W-1:0];
                        r_v[2] <= i_qx[W-1:0];
                        r_v[3] <= i_qy[W-1:0];
                        r_v[4] <= r_cfg_a[W-1:0];
                        r_m    <= m_eff;
                        r_acc  <= '0;
                        r_cnt  <= '0;
                        r_ridx <= '0;
                        r_state <= S_RED;
                    end
                end
                S_RED: begin
                    if (r_cnt == CNT_W'(W-1)) begin
                        r_v[0] <= r_v[1];
                        r_v[1] <= r_v[2];
                        r_v[2] <= r_v[3];
                        r_v[3] <= r_v[4];
                        r_v[4] <= u_res;
                        r_acc  <= '0;
                        r_cnt  <= '0;
                        r_ridx <= r_ridx + 3'd1;
                        if (r_ridx == 3'd4) begin
                            r_state <= S_CHK;
                        end
                    end else begin
                        r_acc  <= u_res;
                        r_v[0] <= {r_v[0][W-2:0], 1'b0};
                        r_cnt  <= r_cnt + CNT_W'(1);
                    end
                end
                S_CHK: begin
                    if (r_v[0] == r_v[2] && u_res == '0) begin
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_inf   <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_v[0] == r_v[2] && r_v[1] == r_v[3]) begin
                        r_ma    <= r_v[0];
                        r_mb    <= r_v[0];
                        r_acc   <= '0;
                        r_cnt   <= '0;
                        r_ret   <= S_DBL_A1;
                        r_state <= S_MUL_D;
                    end else begin
                        r_state <= S_GEN_NUM;
                    end
                end
                S_MUL_D: begin
                    r_acc   <= u_res;
                    r_state <= S_MUL_A;
                end
                S_MUL_A: begin
                    if (r_mb[W-1]) begin
                        r_acc <= u_res;
                    end
                    r_mb <= {r_mb[W-2:0], 1'b0};
                    if (r_cnt == CNT_W'(W-1)) begin
                        r_cnt   <= '0;
                        r_state <= r_ret;
                    end else begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_MUL_D;
                    end
                end
                S_DBL_A1:  begin r_num <= u_res; r_state <= S_DBL_A2;  end
                S_DBL_A2:  begin r_num <= u_res; r_state <= S_DBL_A3;  end
                S_DBL_A3:  begin r_num <= u_res; r_state <= S_DBL_DEN; end
                S_DBL_DEN: begin r_den <= u_res; r_state <= S_INV_INIT; end
                S_GEN_NUM: begin r_num <= u_res; r_state <= S_GEN_DEN; end
                S_GEN_DEN: begin r_den <= u_res; r_state <= S_INV_INIT; end
                S_INV_INIT: begin
                    r_r0    <= r_m;
                    r_r1    <= r_den;
                    r_t0    <= '0;
                    r_t1    <= W'(1);
                    r_state <= S_INV_TEST;
                end
                S_INV_TEST: begin
                    if (r_r1 == '0) begin
                        r_state <= S_INV_FIN;
                    end else begin
                        r_d     <= {1'b0, r_r1};
                        r_k     <= '0;
                        r_acc   <= '0;
                        r_state <= S_INV_GROW;
                    end
                end
                S_INV_GROW: begin
                    if (d_dbl <= {1'b0, r_r0}) begin
                        r_d <= d_dbl;
                        r_k <= r_k + K_W'(1);
                    end else begin
                        r_state <= S_INV_DBL;
                    end
                end
                S_INV_DBL: begin
                    r_acc <= u_res;
                    r_qb  <= !rem_dif[W];
                    if (!rem_dif[W]) begin
                        r_r0 <= rem_dif[W-1:0];
                    end
                    r_state <= S_INV_ADD;
                end
                S_INV_ADD: begin
                    if (r_qb) begin
                        r_acc <= u_res;
                    end
                    r_d <= {1'b0, r_d[W:1]};
                    if (r_k == '0) begin
                        r_state <= S_INV_SUB;
                    end else begin
                        r_k     <= r_k - K_W'(1);
                        r_state <= S_INV_DBL;
                    end
                end
                S_INV_SUB: begin
                    r_t1    <= u_res;
                    r_t0    <= r_t1;
                    r_r0    <= r_r1;
                    r_r1    <= r_r0;
                    r_state <= S_INV_TEST;
                end
                S_INV_FIN: begin
                    r_ma    <= r_num;
                    r_mb    <= (r_r0 == W'(1)) ? r_t0 : '0;
                    r_acc   <= '0;
                    r_cnt   <= '0;
                    r_ret   <= S_S_SQ;
                    r_state <= S_MUL_D;
                end
                S_S_SQ: begin
                    r_s     <= r_acc;
                    r_ma    <= r_acc;
                    r_mb    <= r_acc;
                    r_acc   <= '0;
                    r_ret   <= S_RX1;
                    r_state <= S_MUL_D;
                end
                S_RX1: begin r_num <= u_res; r_state <= S_RX2; end
                S_RX2: begin r_num <= u_res; r_state <= S_DX;  end
                S_DX: begin
                    r_ma    <= r_s;
                    r_mb    <= u_res;
                    r_acc   <= '0;
                    r_ret   <= S_RY;
                    r_state <= S_MUL_D;
                end
                S_RY: begin
                    r_rx    <= r_num;
                    r_ry    <= u_res;
                    r_inf   <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy        = (r_state != S_IDLE);
    assign o_cfg_ready   = (r_state == S_IDLE);
    assign o_valid       = r_valid;
    assign o_rx          = DATA_W'(r_rx);
    assign o_ry          = DATA_W'(r_ry);
    assign o_at_infinity = r_inf;
endmodule

[rtl/core/ecpa_port_chk.sv]
// Port-level checker for the point adder, attached by bind.
// Depends on ecpa_pkg and ec_point_add_prime_field.
module ecpa_port_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_start,
    input logic                        o_busy,
    input logic                        o_valid,
    input logic [ecpa_pkg::DATA_W-1:0] o_rx,
    input logic [ecpa_pkg::DATA_W-1:0] o_ry,
    input logic                        o_at_infinity
);
    import ecpa_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("request accepted but block not busy");

    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_busy)
        else $error("result strobe while busy");

    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> o_valid)
        else $error("request finished without result");

    a_inf_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_at_infinity |-> (o_rx == '0) && (o_ry == '0))
        else $error("infinity result with nonzero coordinates");
endmodule

bind ec_point_add_prime_field ecpa_port_chk u_ecpa_port_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_rx          (o_rx),
    .o_ry          (o_ry),
    .o_at_infinity (o_at_infinity)
);

[sim/tb.sv]
// Self-checking bench for ec_point_add_prime_field: directed and random point additions
// under many moduli, each result checked against an in-bench modular-arithmetic predictor.
// Depends on ecpa_pkg and the RTL top level.
module tb;
    import ecpa_pkg::*;

    typedef logic [DATA_W-1:0] fe_t;
    typedef struct packed {
        fe_t  rx;
        fe_t  ry;
        logic inf;
    } sum_t;

    localparam int WATCHDOG_LIMIT = 60000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_start = 1'b0;
    fe_t  i_px = '0, i_py = '0, i_qx = '0, i_qy = '0;
    logic i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_MODULUS;
    fe_t  i_cfg_data = '0;
    logic o_busy, o_valid, o_at_infinity, o_cfg_ready;
    fe_t  o_rx, o_ry;

    fe_t  model_mod = 64'd3;
    fe_t  model_a = 64'd0;
    sum_t pending_sums[$];
    int   errors = 0;
    int   sender_idle_pct = 0;
    int   stall_count = 0;

    always #6 i_clk = ~i_clk;

    ec_point_add_prime_field dut (.*);

    function automatic fe_t add_mod(fe_t a, fe_t b, fe_t m);
        logic [DATA_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) s = s - {1'b0, m};
        return s[DATA_W-1:0];
    endfunction

    function automatic fe_t sub_mod(fe_t a, fe_t b, fe_t m);
        return (a >= b) ? a - b : a - b + m;
    endfunction

    function automatic fe_t mul_mod(fe_t a, fe_t b, fe_t m);
        logic [2*DATA_W-1:0] p;
        p = {{DATA_W{1'b0}}, a} * {{DATA_W{1'b0}}, b};
        return fe_t'(p % {{DATA_W{1'b0}}, m});
    endfunction

    function automatic fe_t inv_mod(fe_t a, fe_t m);
        fe_t r0, r1, t0, t1, q, tmp;
        r0 = m; r1 = a; t0 = '0; t1 = 64'd1;
        while (r1 != 0) begin
            q = r0 / r1;
            tmp = r0 - q * r1;
            r0 = r1;
            r1 = tmp;
            tmp = sub_mod(t0, mul_mod(q % m, t1, m), m);
            t0 = t1;
            t1 = tmp;
        end
        return (r0 == 64'd1) ? t0 : '0;
    endfunction

    function automatic sum_t point_sum(fe_t ipx, fe_t ipy, fe_t iqx, fe_t iqy);
        fe_t m, px, py, qx, qy, a, num, den, s;
        sum_t r;
        m = (model_mod < 64'd3) ? 64'd3 : model_mod;
        px = ipx % m; py = ipy % m; qx = iqx % m; qy = iqy % m; a = model_a % m;
        r = '0;
        if (px == qx && add_mod(py, qy, m) == 0) begin
            r.inf = 1'b1;
            return r;
        end
        if (px == qx && py == qy) begin
            num = add_mod(mul_mod(3 % m, mul_mod(px, px, m), m), a, m);
            den = add_mod(py, py, m);
        end else begin
            num = sub_mod(qy, py, m);
            den = sub_mod(qx, px, m);
        end
        s = mul_mod(num, inv_mod(den, m), m);
        r.rx = sub_mod(sub_mod(mul_mod(s, s, m), px, m), qx, m);
        r.ry = sub_mod(mul_mod(s, sub_mod(px, r.rx, m), m), py, m);
        return r;
    endfunction

    function automatic fe_t rand_fe();
        return {$urandom, $urandom};
    endfunction

    always @(posedge i_clk) begin
        sum_t exp_sum;
        if (i_rst_n && o_valid) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result rx=%h ry=%h inf=%b",
                         $time, o_rx, o_ry, o_at_infinity);
                errors++;
            end else begin
                exp_sum = pending_sums.pop_front();
                if (o_rx !== exp_sum.rx) begin
                    $display("%0t: rx expected %h actual %h", $time, exp_sum.rx, o_rx);
                    errors++;
                end
                if (o_ry !== exp_sum.ry) begin
                    $display("%0t: ry expected %h actual %h", $time, exp_sum.ry, o_ry);
                    errors++;
                end
                if (o_at_infinity !== exp_sum.inf) begin
                    $display("%0t: at_infinity expected %b actual %b",
                             $time, exp_sum.inf, o_at_infinity);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))
            stall_count <= 0;
        else
            stall_count <= stall_count + 1;
        if (stall_count >= WATCHDOG_LIMIT) begin
            $display("** ec_point_add_prime_field: FAILED **");
            $finish;
        end
    end

    // Leaves i_start high unless it paused; the next request or end_burst drives it.
    task automatic send_request(fe_t px, fe_t py, fe_t qx, fe_t qy);
        int gap;
        i_start <= 1'b1;
        i_px <= px; i_py <= py; i_qx <= qx; i_qy <= qy;
        do @(posedge i_clk); while (!(i_start && !o_busy));
        pending_sums.push_back(point_sum(px, py, qx, qy));
        if ($urandom_range(99) < sender_idle_pct) begin
            i_start <= 1'b0;
            gap = $urandom_range(1, 40);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic end_burst();
        i_start <= 1'b0;
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, fe_t data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        if (idx == CFG_MODULUS) model_mod = data;
        else if (idx == CFG_CURVE_A) model_a = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_curve(fe_t m, fe_t a);
        write_reg(CFG_MODULUS, m);
        write_reg(CFG_CURVE_A, a);
    endtask

    task automatic send_random(int count);
        fe_t m, px, py, qx, qy;
        int kind;
        m = (model_mod < 64'd3) ? 64'd3 : model_mod;
        repeat (count) begin
            px = rand_fe() % m; py = rand_fe() % m;
            qx = rand_fe() % m; qy = rand_fe() % m;
            kind = $urandom_range(99);
            if (kind < 20) begin
                qx = px; qy = py;
            end else if (kind < 35) begin
                qx = px; qy = sub_mod(0, py, m);
            end else if (kind < 45) begin
                qx = px;
            end else if (kind < 52) begin
                qx = px; qy = py; py = '0; qy = '0;
            end else if (kind < 62) begin
                px = rand_fe(); py = rand_fe(); qx = rand_fe(); qy = rand_fe();
            end
            send_request(px, py, qx, qy);
        end
        end_burst();
    endtask

    task automatic test_reset_values();
        send_request(64'd1, 64'd1, 64'd1, 64'd2);
        send_request(64'd0, 64'd1, 64'd1, 64'd0);
        send_request(64'd2, 64'd1, 64'd2, 64'd1);
        end_burst();
    endtask

    task automatic test_directed();
        fe_t ones;
        ones = '1;
        set_curve(64'hFFFF_FFFF_FFFF_FFC5, ones);
        send_request(64'd0, 64'd0, 64'd0, 64'd0);
        send_request(ones, ones, ones, ones);
        send_request(64'd5, 64'd7, 64'd5, 64'hFFFF_FFFF_FFFF_FFBE);
        send_request(64'd5, 64'd7, 64'd5, 64'd7);
        send_request(64'd5, 64'd7, 64'd5, 64'd9);
        send_request(64'd1, 64'd2, 64'hFFFF_FFFF_FFFF_FFC4, 64'd3);
        send_request(64'hFFFF_FFFF_FFFF_FFC5, 64'd1, 64'd0, 64'd1);
        send_request(64'd3, 64'd0, 64'd3, 64'd0);
        end_burst();
        set_curve(64'd0, 64'd5);
        send_request(64'd1, 64'd1, 64'd1, 64'd1);
        send_request(64'd1, 64'd2, 64'd2, 64'd2);
        end_burst();
        set_curve(64'd2, 64'd0);
        send_request(64'd4, 64'd1, 64'd2, 64'd1);
        end_burst();
        set_curve(64'd15, 64'd2);
        send_request(64'd1, 64'd2, 64'd4, 64'd7);
        send_request(64'd3, 64'd3, 64'd3, 64'd3);
        end_burst();
        set_curve(ones, ones);
        send_request(64'd1, 64'd2, 64'd3, 64'd4);
        send_request(ones, 64'd1, 64'd7, 64'd0);
        end_burst();
    endtask

    task automatic test_random();
        fe_t moduli[10];
        int p;
        moduli = '{64'd7, 64'd97, 64'd65521, 64'h7FFF_FFFF, 64'h1FFF_FFFF_FFFF_FFFF,
                   64'hFFFF_FFFF_FFFF_FFC5, 64'd3, 64'hFFFF_FFFF_0000_0001,
                   64'd1_000_003, 64'hFFFF_FFFF_FFFF_FFFF};
        for (p = 0; p < 9; p++) begin
            sender_idle_pct = (p < 3) ? 25 : (p < 6) ? 57 : 0;
            set_curve(moduli[$urandom_range(9)], ($urandom_range(3) == 0) ? '1 : rand_fe());
            send_random(200);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_directed();
        test_random();
        repeat (200) @(posedge i_clk);
        if (errors == 0)
            $display("** ec_point_add_prime_field: PASSED **");
        else
            $display("** ec_point_add_prime_field: FAILED **");
        $finish;
    end
endmodule
